// ===== rtl/tst_pkg.sv =====
// Shared constants, state types and job layout helper for the triangle strip tessellator.
package tst_pkg;

    // Default sizes
    localparam int MAX_STRIPS_DEF = 10;
    localparam int COORD_BITS_DEF = 16;

    // Fixed port and counter widths
    localparam int VEC_BITS    = 48;
    localparam int STRIP_BITS  = 4;
    localparam int SLOT_BITS   = 3;
    localparam int REM_BITS    = 4;
    localparam int LANES       = 3;
    localparam int LEG_LANES   = 6;
    localparam int QUEUE_DEPTH = 2;

    // Last slot of a strip (six vertices) and of the top triangle (three)
    localparam logic [SLOT_BITS-1:0] SLOT_STRIP_END = 3'd5;
    localparam logic [SLOT_BITS-1:0] SLOT_TOP_END   = 3'd2;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_STRIP,
        B_TOP
    } back_state_t;

    // Width of one queued job: six vectors, strip count, per leg-lane
    // quotient, remainder and sign
    function automatic int job_bits(input int cb);
        return 6 * LANES * cb + STRIP_BITS + LEG_LANES * (cb + REM_BITS + 1);
    endfunction

endpackage

// ===== rtl/tst_front.sv =====
// Front end: takes a triangle, clamps the strip count and divides each leg delta by it.
module tst_front
    import tst_pkg::*;
#(
    parameter int MAX_STRIPS = MAX_STRIPS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [VEC_BITS-1:0]             corner_bottom_left,
    input  logic [VEC_BITS-1:0]             corner_bottom_right,
    input  logic [VEC_BITS-1:0]             corner_top,
    input  logic [VEC_BITS-1:0]             normal_left,
    input  logic [VEC_BITS-1:0]             normal_right,
    input  logic [VEC_BITS-1:0]             normal_top,
    input  logic [STRIP_BITS-1:0]           subdivision_count,
    input  logic                            queue_full,
    output logic                            push,
    output logic [job_bits(COORD_BITS)-1:0] job
);

    localparam int CB    = COORD_BITS;
    localparam int VW    = LANES * CB;
    localparam int CNT_W = $clog2(CB + 1);

    front_state_t state_reg, state_next;

    logic                  accept;
    logic                  div_step;
    logic [CNT_W-1:0]      cnt_reg;
    logic [VW-1:0]         bl_reg, br_reg, tp_reg, nl_reg, nr_reg, nt_reg;
    logic [STRIP_BITS-1:0] n_reg, n_sat;
    logic [CB-1:0]         dq_reg  [LEG_LANES];
    logic [REM_BITS-1:0]   dr_reg  [LEG_LANES];
    logic                  sg_reg  [LEG_LANES];
    logic [LEG_LANES*CB-1:0]       q_flat;
    logic [LEG_LANES*REM_BITS-1:0] r_flat;
    logic [LEG_LANES-1:0]          s_flat;

    // Strip count: zero acts as one, large values clamp
    always_comb
    begin
        if (subdivision_count == '0)
            n_sat = STRIP_BITS'(1);
        else if (subdivision_count > STRIP_BITS'(MAX_STRIPS))
            n_sat = STRIP_BITS'(MAX_STRIPS);
        else
            n_sat = subdivision_count;
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE:
            begin
                if (start)
                    state_next = F_DIV;
            end
            F_DIV:
            begin
                if (cnt_reg == CNT_W'(CB - 1))
                    state_next = F_PUSH;
            end
            F_PUSH:
            begin
                if (!queue_full)
                    state_next = F_IDLE;
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    // Control outputs
    always_comb
    begin
        busy     = (state_reg != F_IDLE);
        accept   = start && (state_reg == F_IDLE);
        div_step = (state_reg == F_DIV);
        push     = (state_reg == F_PUSH) && !queue_full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
                cnt_reg <= '0;
            else if (div_step)
                cnt_reg <= cnt_reg + CNT_W'(1);
        end
    end

    // Triangle capture, masked to the packed lanes
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bl_reg <= corner_bottom_left[VW-1:0];
            br_reg <= corner_bottom_right[VW-1:0];
            tp_reg <= corner_top[VW-1:0];
            nl_reg <= normal_left[VW-1:0];
            nr_reg <= normal_right[VW-1:0];
            nt_reg <= normal_top[VW-1:0];
            n_reg  <= n_sat;
        end
    end

    // One restoring divider per leg and lane: |top - bottom| / n, one bit a cycle
    for (genvar j = 0; j < LEG_LANES; j++)
    begin : g_div
        localparam int LANE = j % LANES;
        logic [CB-1:0]         base_lane, top_lane;
        logic [CB:0]           diff, mag;
        logic [REM_BITS:0]     trial;
        logic                  fits;

        assign base_lane = (j < LANES) ? corner_bottom_left[LANE*CB +: CB]
                                       : corner_bottom_right[LANE*CB +: CB];
        assign top_lane  = corner_top[LANE*CB +: CB];
        assign diff      = {top_lane[CB-1], top_lane} - {base_lane[CB-1], base_lane};
        assign mag       = diff[CB] ? (CB+1)'(-diff) : diff;
        assign trial     = {dr_reg[j], dq_reg[j][CB-1]};
        assign fits      = (trial >= {1'b0, n_reg});

        always_ff @(posedge clk)
        begin
            if (accept)
            begin
                dq_reg[j] <= mag[CB-1:0];
                dr_reg[j] <= '0;
                sg_reg[j] <= diff[CB];
            end
            else if (div_step)
            begin
                dq_reg[j] <= {dq_reg[j][CB-2:0], fits};
                dr_reg[j] <= fits ? REM_BITS'(trial - {1'b0, n_reg}) : trial[REM_BITS-1:0];
            end
        end

        assign q_flat[j*CB +: CB]             = dq_reg[j];
        assign r_flat[j*REM_BITS +: REM_BITS] = dr_reg[j];
        assign s_flat[j]                      = sg_reg[j];
    end

    // Job layout, lowest bits first: BL, BR, T, NL, NR, NT, n, quotients, remainders, signs
    assign job = {s_flat, r_flat, q_flat, n_reg, nt_reg, nr_reg, nl_reg, tp_reg, br_reg, bl_reg};

`ifndef SYNTHESIS
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !queue_full)
        else $error("front pushed into a full queue");
    a_accept_div: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == F_DIV) && (cnt_reg == '0))
        else $error("accepted item did not start division");
    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == F_DIV) |-> busy && !push)
        else $error("front idle or pushing during division");
`endif

endmodule

// ===== rtl/tst_queue.sv =====
// Two-entry job queue between front end and back end.
module tst_queue
    import tst_pkg::*;
#(
    parameter int DATA_W = job_bits(COORD_BITS_DEF)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] wr_data,
    output logic              full,
    input  logic              pop,
    output logic [DATA_W-1:0] rd_data,
    output logic              empty
);

    // depth is a power of two, pointers wrap naturally
    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [DATA_W-1:0] entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign full    = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = entry_reg[rd_ptr_reg];

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= wr_data;
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            if (push && !pop)
                count_reg <= count_reg + CNT_W'(1);
            else if (pop && !push)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

// ===== rtl/tst_back.sv =====
// Back end: walks the strips and emits one vertex item per cycle.
module tst_back
    import tst_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            empty,
    input  logic [job_bits(COORD_BITS)-1:0] rd_data,
    output logic                            pop,
    output logic                            vertex_valid,
    output logic [VEC_BITS-1:0]             vertex_position,
    output logic [VEC_BITS-1:0]             vertex_normal,
    output logic                            last_vertex
);

    localparam int CB  = COORD_BITS;
    localparam int VW  = LANES * CB;
    localparam int O_N = 6 * VW;
    localparam int O_Q = O_N + STRIP_BITS;
    localparam int O_R = O_Q + LEG_LANES * CB;
    localparam int O_S = O_R + LEG_LANES * REM_BITS;

    back_state_t state_reg, state_next;

    logic [VW-1:0]         bl_reg, br_reg, tp_reg, nl_reg, nr_reg, nt_reg;
    logic [STRIP_BITS-1:0] n_reg, job_n;
    logic [STRIP_BITS-1:0] strip_index_reg;
    logic [SLOT_BITS-1:0]  vertex_slot_reg;
    logic [CB-1:0]         step_q_reg [LEG_LANES];
    logic [REM_BITS-1:0]   step_r_reg [LEG_LANES];
    logic                  sg_reg     [LEG_LANES];
    logic [CB-1:0]         cur_q_reg  [LEG_LANES];
    logic [REM_BITS-1:0]   cur_r_reg  [LEG_LANES];
    logic [CB-1:0]         nxt_q_reg  [LEG_LANES];
    logic [REM_BITS-1:0]   nxt_r_reg  [LEG_LANES];
    logic [VW-1:0]         l_cur, r_cur, l_nxt, r_nxt;
    logic [VW-1:0]         pos_sel, nrm_sel;
    logic                  emit, advance, finish, last_strip;

    logic                  vertex_valid_reg, last_vertex_reg;
    logic [VEC_BITS-1:0]   vertex_position_reg, vertex_normal_reg;

    assign job_n      = rd_data[O_N +: STRIP_BITS];
    assign last_strip = (strip_index_reg + STRIP_BITS'(1)) == (n_reg - STRIP_BITS'(1));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!empty)
                    state_next = (job_n > STRIP_BITS'(1)) ? B_STRIP : B_TOP;
            end
            B_STRIP:
            begin
                if (vertex_slot_reg == SLOT_STRIP_END && last_strip)
                    state_next = B_TOP;
            end
            B_TOP:
            begin
                if (vertex_slot_reg == SLOT_TOP_END)
                    state_next = B_IDLE;
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Control and vertex selection
    always_comb
    begin
        pop     = 1'b0;
        emit    = 1'b0;
        advance = 1'b0;
        finish  = 1'b0;
        pos_sel = l_cur;
        nrm_sel = nl_reg;
        case (state_reg)
            B_IDLE:
            begin
                pop = !empty;
            end
            B_STRIP:
            begin
                emit    = 1'b1;
                advance = (vertex_slot_reg == SLOT_STRIP_END);
                // Lk, Rk, Rk+1, Lk, Rk+1, Lk+1
                case (vertex_slot_reg)
                    3'd1:
                    begin
                        pos_sel = r_cur;
                        nrm_sel = nr_reg;
                    end
                    3'd2, 3'd4:
                    begin
                        pos_sel = r_nxt;
                        nrm_sel = nr_reg;
                    end
                    3'd5:
                    begin
                        pos_sel = l_nxt;
                        nrm_sel = nl_reg;
                    end
                    default:
                    begin
                        pos_sel = l_cur;
                        nrm_sel = nl_reg;
                    end
                endcase
            end
            B_TOP:
            begin
                emit   = 1'b1;
                finish = (vertex_slot_reg == SLOT_TOP_END);
                // L(n-1), R(n-1), apex
                case (vertex_slot_reg)
                    3'd0:
                    begin
                        pos_sel = l_cur;
                        nrm_sel = nl_reg;
                    end
                    3'd1:
                    begin
                        pos_sel = r_cur;
                        nrm_sel = nr_reg;
                    end
                    default:
                    begin
                        pos_sel = tp_reg;
                        nrm_sel = nt_reg;
                    end
                endcase
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // State and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= B_IDLE;
            strip_index_reg <= '0;
            vertex_slot_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
            begin
                strip_index_reg <= '0;
                vertex_slot_reg <= '0;
            end
            else if (emit)
            begin
                if (advance || finish)
                    vertex_slot_reg <= '0;
                else
                    vertex_slot_reg <= vertex_slot_reg + SLOT_BITS'(1);
                if (advance)
                    strip_index_reg <= strip_index_reg + STRIP_BITS'(1);
                else if (finish)
                    strip_index_reg <= '0;
            end
        end
    end

    // Job capture
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            bl_reg <= rd_data[0*VW +: VW];
            br_reg <= rd_data[1*VW +: VW];
            tp_reg <= rd_data[2*VW +: VW];
            nl_reg <= rd_data[3*VW +: VW];
            nr_reg <= rd_data[4*VW +: VW];
            nt_reg <= rd_data[5*VW +: VW];
            n_reg  <= job_n;
        end
    end

    // Leg points by running quotient and remainder: point i holds |d|*i/n
    for (genvar j = 0; j < LEG_LANES; j++)
    begin : g_leg
        localparam int LANE = j % LANES;
        logic [REM_BITS:0]   sum_r;
        logic                wrap;
        logic [CB-1:0]       new_q;
        logic [REM_BITS-1:0] new_r;
        logic [CB-1:0]       base_lane, cur_pt, nxt_pt;

        assign sum_r = {1'b0, nxt_r_reg[j]} + {1'b0, step_r_reg[j]};
        assign wrap  = (sum_r >= {1'b0, n_reg});
        assign new_r = wrap ? REM_BITS'(sum_r - {1'b0, n_reg}) : sum_r[REM_BITS-1:0];
        assign new_q = nxt_q_reg[j] + step_q_reg[j] + CB'(wrap);

        assign base_lane = (j < LANES) ? bl_reg[LANE*CB +: CB] : br_reg[LANE*CB +: CB];
        assign cur_pt    = sg_reg[j] ? base_lane - cur_q_reg[j] : base_lane + cur_q_reg[j];
        assign nxt_pt    = sg_reg[j] ? base_lane - nxt_q_reg[j] : base_lane + nxt_q_reg[j];

        if (j < LANES)
        begin : g_left
            assign l_cur[LANE*CB +: CB] = cur_pt;
            assign l_nxt[LANE*CB +: CB] = nxt_pt;
        end
        else
        begin : g_right
            assign r_cur[LANE*CB +: CB] = cur_pt;
            assign r_nxt[LANE*CB +: CB] = nxt_pt;
        end

        always_ff @(posedge clk)
        begin
            if (pop)
            begin
                step_q_reg[j] <= rd_data[O_Q + j*CB +: CB];
                step_r_reg[j] <= rd_data[O_R + j*REM_BITS +: REM_BITS];
                sg_reg[j]     <= rd_data[O_S + j];
                cur_q_reg[j]  <= '0;
                cur_r_reg[j]  <= '0;
                nxt_q_reg[j]  <= rd_data[O_Q + j*CB +: CB];
                nxt_r_reg[j]  <= rd_data[O_R + j*REM_BITS +: REM_BITS];
            end
            else if (advance)
            begin
                cur_q_reg[j] <= nxt_q_reg[j];
                cur_r_reg[j] <= nxt_r_reg[j];
                nxt_q_reg[j] <= new_q;
                nxt_r_reg[j] <= new_r;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_valid_reg <= 1'b0;
            last_vertex_reg  <= 1'b0;
        end
        else
        begin
            vertex_valid_reg <= emit;
            last_vertex_reg  <= finish;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            vertex_position_reg <= VEC_BITS'(pos_sel);
            vertex_normal_reg   <= VEC_BITS'(nrm_sel);
        end
    end

    assign vertex_valid    = vertex_valid_reg;
    assign last_vertex     = last_vertex_reg;
    assign vertex_position = vertex_position_reg;
    assign vertex_normal   = vertex_normal_reg;

`ifndef SYNTHESIS
    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        last_vertex_reg |-> vertex_valid_reg)
        else $error("last flag without a vertex");
    a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty && (state_reg == B_IDLE))
        else $error("pop from empty queue or while busy");
    a_strip_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_STRIP) |->
            ({1'b0, strip_index_reg} + (STRIP_BITS+1)'(1)) < {1'b0, n_reg})
        else $error("strip index beyond strip count");
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != B_IDLE) |-> (nxt_r_reg[0] < n_reg) && (cur_r_reg[0] < n_reg))
        else $error("leg remainder not below strip count");
`endif

endmodule

// ===== rtl/triangle_strip_tessellator.sv =====
// Top level of the triangle strip tessellator: config register, front end, queue, back end.
//
// A triangle is taken when start is high and busy is low. With n strips (the
// subdivision_count register, zero read as one, clamped to MAX_STRIPS) it yields
// 6(n-1)+3 vertex items, one per clock on vertex_valid, the last one flagged by
// last_vertex; items cannot be held off. The front end does the bit-serial
// division of the leg deltas and then hands the job to a two-entry queue, so
// busy is high through the division and the hand-off and further while the
// queue is full; a new triangle can be taken only once the front end has
// handed off the last one, while the back end may still be emitting. The back
// end sets the sustained rate for larger n; for small n the divider sets it.
// Write subdivision_count only while no triangle is in flight.
module triangle_strip_tessellator
    import tst_pkg::*;
#(
    parameter int MAX_STRIPS = MAX_STRIPS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [VEC_BITS-1:0]   corner_bottom_left,
    input  logic [VEC_BITS-1:0]   corner_bottom_right,
    input  logic [VEC_BITS-1:0]   corner_top,
    input  logic [VEC_BITS-1:0]   normal_left,
    input  logic [VEC_BITS-1:0]   normal_right,
    input  logic [VEC_BITS-1:0]   normal_top,
    input  logic                  cfg_wr_en,
    input  logic [STRIP_BITS-1:0] cfg_wr_data,
    output logic                  vertex_valid,
    output logic [VEC_BITS-1:0]   vertex_position,
    output logic [VEC_BITS-1:0]   vertex_normal,
    output logic                  last_vertex
);

    localparam int JOB_W = job_bits(COORD_BITS);

    logic [STRIP_BITS-1:0] subdivision_count_reg;
    logic                  push, pop, full, empty;
    logic [JOB_W-1:0]      wr_job, rd_job;

    // Strip count register, resets to one strip
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            subdivision_count_reg <= STRIP_BITS'(1);
        else if (cfg_wr_en)
            subdivision_count_reg <= cfg_wr_data;
    end

    tst_front #(
        .MAX_STRIPS (MAX_STRIPS),
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk                 (clk),
        .rst_n               (rst_n),
        .start               (start),
        .busy                (busy),
        .corner_bottom_left  (corner_bottom_left),
        .corner_bottom_right (corner_bottom_right),
        .corner_top          (corner_top),
        .normal_left         (normal_left),
        .normal_right        (normal_right),
        .normal_top          (normal_top),
        .subdivision_count   (subdivision_count_reg),
        .queue_full          (full),
        .push                (push),
        .job                 (wr_job)
    );

    tst_queue #(
        .DATA_W (JOB_W)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (wr_job),
        .full    (full),
        .pop     (pop),
        .rd_data (rd_job),
        .empty   (empty)
    );

    tst_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .empty           (empty),
        .rd_data         (rd_job),
        .pop             (pop),
        .vertex_valid    (vertex_valid),
        .vertex_position (vertex_position),
        .vertex_normal   (vertex_normal),
        .last_vertex     (last_vertex)
    );

endmodule

// ===== tb/sv/tessellation_checker.sv =====
// Checker for the triangle strip tessellator: predicts each mesh and compares the vertex items.
`timescale 1ns / 100ps

module tessellation_checker
    import tst_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic [VEC_BITS-1:0]   corner_bottom_left,
    input  logic [VEC_BITS-1:0]   corner_bottom_right,
    input  logic [VEC_BITS-1:0]   corner_top,
    input  logic [VEC_BITS-1:0]   normal_left,
    input  logic [VEC_BITS-1:0]   normal_right,
    input  logic [VEC_BITS-1:0]   normal_top,
    input  logic                  cfg_wr_en,
    input  logic [STRIP_BITS-1:0] cfg_wr_data,
    input  logic                  vertex_valid,
    input  logic [VEC_BITS-1:0]   vertex_position,
    input  logic [VEC_BITS-1:0]   vertex_normal,
    input  logic                  last_vertex,
    output int                    mismatch_count,
    output int                    vertices_pending
);

    localparam int CB = COORD_BITS_DEF;

    typedef logic [VEC_BITS-1:0] vec_t;

    typedef struct {
        vec_t position;
        vec_t normal;
        logic last;
    } vertex_t;

    // shadow of subdivision_count and the vertices still owed by the block
    logic [STRIP_BITS-1:0] strip_setting;
    vertex_t               mesh_vertices[$];
    vertex_t               want;

    // point 'step' of 'strips' on the leg from a bottom corner to the apex, lane by lane
    function automatic vec_t leg_point(vec_t corner, vec_t apex, int step, int strips);
        vec_t res;
        int   lane;
        int   a;
        int   b;
        int   p;
        res = '0;
        for (lane = 0; lane < LANES; lane++)
        begin
            a = int'($signed(corner[lane*CB +: CB]));
            b = int'($signed(apex[lane*CB +: CB]));
            // int division truncates toward zero
            p = a + ((b - a) * step) / strips;
            res[lane*CB +: CB] = p[CB-1:0];
        end
        return res;
    endfunction

    function automatic void queue_vertex(vec_t pos, vec_t nrm);
        vertex_t v;
        v.position = pos;
        v.normal   = nrm;
        v.last     = 1'b0;
        mesh_vertices.insert(mesh_vertices.size(), v);
    endfunction

    // whole mesh of one triangle at the current strip setting
    function automatic void predict_mesh(vec_t bl, vec_t br, vec_t tp,
                                         vec_t nl, vec_t nr, vec_t nt);
        int   strips;
        int   k;
        vec_t l0;
        vec_t r0;
        vec_t l1;
        vec_t r1;
        strips = int'(strip_setting);
        // zero reads as one, large counts saturate
        if (strips == 0)
            strips = 1;
        if (strips > MAX_STRIPS_DEF)
            strips = MAX_STRIPS_DEF;
        for (k = 0; k < strips - 1; k++)
        begin
            l0 = leg_point(bl, tp, k, strips);
            r0 = leg_point(br, tp, k, strips);
            l1 = leg_point(bl, tp, k + 1, strips);
            r1 = leg_point(br, tp, k + 1, strips);
            queue_vertex(l0, nl);
            queue_vertex(r0, nr);
            queue_vertex(r1, nr);
            queue_vertex(l0, nl);
            queue_vertex(r1, nr);
            queue_vertex(l1, nl);
        end
        // top triangle closes the mesh
        queue_vertex(leg_point(bl, tp, strips - 1, strips), nl);
        queue_vertex(leg_point(br, tp, strips - 1, strips), nr);
        queue_vertex(tp, nt);
        mesh_vertices[mesh_vertices.size() - 1].last = 1'b1;
    endfunction

    // watch the vertex, triangle and register channels at each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strip_setting = 4'd1;
            mesh_vertices.delete();
            vertices_pending = 0;
        end
        else
        begin
            // vertex item leaving the block
            if (vertex_valid)
            begin
                if (mesh_vertices.size() == 0)
                begin
                    $display("%0t: vertex item with none predicted, position %h normal %h",
                             $time, vertex_position, vertex_normal);
                    mismatch_count++;
                end
                else
                begin
                    want = mesh_vertices.pop_front();
                    if (vertex_position !== want.position)
                    begin
                        $display("%0t: vertex_position expected %h actual %h",
                                 $time, want.position, vertex_position);
                        mismatch_count++;
                    end
                    if (vertex_normal !== want.normal)
                    begin
                        $display("%0t: vertex_normal expected %h actual %h",
                                 $time, want.normal, vertex_normal);
                        mismatch_count++;
                    end
                    if (last_vertex !== want.last)
                    begin
                        $display("%0t: last_vertex expected %b actual %b",
                                 $time, want.last, last_vertex);
                        mismatch_count++;
                    end
                end
            end
            // triangle taken
            if (start && !busy)
                predict_mesh(corner_bottom_left, corner_bottom_right, corner_top,
                             normal_left, normal_right, normal_top);
            // register write
            if (cfg_wr_en)
                strip_setting = cfg_wr_data;
            vertices_pending = mesh_vertices.size();
        end
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench top for the triangle strip tessellator: clock, reset, triangle stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
    import tst_pkg::*;

    typedef logic [VEC_BITS-1:0] vec_t;

    localparam int   RANDOM_ITEMS = 155;
    localparam int   CALM_FROM    = 125;  // no idling once this many random items are in
    localparam int   SETTLE       = 80;   // cycles to cover divider plus the longest mesh
    localparam vec_t ALL_MIN      = 48'h8000_8000_8000;
    localparam vec_t ALL_MAX      = 48'h7FFF_7FFF_7FFF;
    localparam vec_t ALL_ONES     = 48'hFFFF_FFFF_FFFF;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    vec_t                  corner_bottom_left;
    vec_t                  corner_bottom_right;
    vec_t                  corner_top;
    vec_t                  normal_left;
    vec_t                  normal_right;
    vec_t                  normal_top;
    logic                  cfg_wr_en;
    logic [STRIP_BITS-1:0] cfg_wr_data;
    logic                  vertex_valid;
    vec_t                  vertex_position;
    vec_t                  vertex_normal;
    logic                  last_vertex;
    int                    mismatch_count;
    int                    vertices_pending;
    int                    random_sent;
    bit                    calm;

    triangle_strip_tessellator dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .start               (start),
        .busy                (busy),
        .corner_bottom_left  (corner_bottom_left),
        .corner_bottom_right (corner_bottom_right),
        .corner_top          (corner_top),
        .normal_left         (normal_left),
        .normal_right        (normal_right),
        .normal_top          (normal_top),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data),
        .vertex_valid        (vertex_valid),
        .vertex_position     (vertex_position),
        .vertex_normal       (vertex_normal),
        .last_vertex         (last_vertex)
    );

    tessellation_checker u_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .start               (start),
        .busy                (busy),
        .corner_bottom_left  (corner_bottom_left),
        .corner_bottom_right (corner_bottom_right),
        .corner_top          (corner_top),
        .normal_left         (normal_left),
        .normal_right        (normal_right),
        .normal_top          (normal_top),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data),
        .vertex_valid        (vertex_valid),
        .vertex_position     (vertex_position),
        .vertex_normal       (vertex_normal),
        .last_vertex         (last_vertex),
        .mismatch_count      (mismatch_count),
        .vertices_pending    (vertices_pending)
    );

    // 12 ns clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // random vec3: either fully random or lanes drawn from corner, small or random values
    function automatic vec_t random_vec();
        vec_t v;
        int   lane;
        if ($urandom_range(0, 2) == 0)
            v = vec_t'({$urandom, $urandom});
        else
        begin
            for (lane = 0; lane < LANES; lane++)
            begin
                case ($urandom_range(0, 5))
                    0: v[lane*16 +: 16] = 16'h0000;
                    1: v[lane*16 +: 16] = 16'h7FFF;
                    2: v[lane*16 +: 16] = 16'h8000;
                    3: v[lane*16 +: 16] = 16'hFFFF;
                    4: v[lane*16 +: 16] = 16'($urandom_range(0, 31)) - 16'd16;
                    default: v[lane*16 +: 16] = 16'($urandom);
                endcase
            end
        end
        return v;
    endfunction

    // offer one triangle at a falling edge and hold it until taken
    task automatic send_triangle(vec_t bl, vec_t br, vec_t tp, vec_t nl, vec_t nr, vec_t nt);
        corner_bottom_left  = bl;
        corner_bottom_right = br;
        corner_top          = tp;
        normal_left         = nl;
        normal_right        = nr;
        normal_top          = nt;
        start               = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_random_triangle();
        send_triangle(random_vec(), random_vec(), random_vec(),
                      random_vec(), random_vec(), random_vec());
    endtask

    // occasional gap of idle cycles, its length drawn at random, with noise on the data ports
    task automatic maybe_idle();
        int gap;
        if (!calm && $urandom_range(0, 2) == 0)
        begin
            gap = $urandom_range(1, 3);
            start = 1'b0;
            repeat (gap)
            begin
                corner_bottom_left  = vec_t'({$urandom, $urandom});
                corner_bottom_right = vec_t'({$urandom, $urandom});
                corner_top          = vec_t'({$urandom, $urandom});
                normal_left         = vec_t'({$urandom, $urandom});
                normal_right        = vec_t'({$urandom, $urandom});
                normal_top          = vec_t'({$urandom, $urandom});
                @(negedge clk);
            end
        end
    endtask

    // hold off until every predicted vertex has come out, then let the block settle
    task automatic drain();
        start = 1'b0;
        while (vertices_pending != 0)
            @(negedge clk);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_strips(logic [STRIP_BITS-1:0] value);
        drain();
        cfg_wr_en   = 1'b1;
        cfg_wr_data = value;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
    endtask

    // stimulus
    initial
    begin
        int   phase;
        int   burst;
        int   i;
        logic [STRIP_BITS-1:0] setting;

        rst_n               = 1'b0;
        start               = 1'b0;
        cfg_wr_en           = 1'b0;
        cfg_wr_data         = '0;
        corner_bottom_left  = '0;
        corner_bottom_right = '0;
        corner_top          = '0;
        normal_left         = '0;
        normal_right        = '0;
        normal_top          = '0;
        random_sent         = 0;
        calm                = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        // directed: single triangle at the reset count of one
        send_triangle('0, '0, '0, '0, '0, '0);
        send_triangle(ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
        send_triangle(ALL_MIN, ALL_MAX, ALL_MAX, 48'h0100_0000_0000, ALL_MIN, ALL_MAX);
        send_triangle(ALL_MAX, ALL_MIN, ALL_MIN, ALL_MAX, 48'h0000_0100_0000, ALL_MIN);

        // most strips: full-range legs in both directions, truncation of negatives
        write_strips(4'd10);
        send_triangle(ALL_MIN, ALL_MIN, ALL_MAX, 48'h0000_0000_0100, ALL_ONES, ALL_MAX);
        send_triangle(ALL_MAX, ALL_MAX, ALL_MIN, ALL_MIN, 48'h1234_5678_9ABC, '0);
        send_triangle(48'hFFFD_0005_0001, 48'h0007_FFF9_FFFF, 48'h0004_FFF9_0000,
                      random_vec(), random_vec(), random_vec());
        send_random_triangle();

        // zero strip count behaves as one
        write_strips(4'd0);
        send_triangle(ALL_MIN, ALL_MAX, '0, ALL_ONES, '0, ALL_MAX);
        send_random_triangle();

        // counts above the maximum saturate
        write_strips(4'd15);
        send_triangle(ALL_MIN, ALL_MAX, ALL_ONES, '0, ALL_ONES, ALL_MIN);
        send_random_triangle();
        write_strips(4'd11);
        send_random_triangle();

        // two strips, back to back
        write_strips(4'd2);
        send_random_triangle();
        send_random_triangle();

        // random phases, each under its own strip setting
        phase = 0;
        while (random_sent < RANDOM_ITEMS)
        begin
            if (phase % 4 == 0)
            begin
                case ($urandom_range(0, 3))
                    0: setting = 4'd0;
                    1: setting = 4'd1;
                    2: setting = 4'd10;
                    default: setting = 4'd15;
                endcase
            end
            else
                setting = 4'($urandom_range(0, 15));
            write_strips(setting);
            burst = $urandom_range(8, 20);
            for (i = 0; i < burst && random_sent < RANDOM_ITEMS; i++)
            begin
                calm = (random_sent >= CALM_FROM);
                // now and then wait for the block to empty completely mid phase
                if (i == burst / 2 && phase % 3 == 1)
                    drain();
                maybe_idle();
                send_random_triangle();
                random_sent++;
            end
            phase++;
        end

        drain();
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/tst_pkg.sv
rtl/tst_front.sv
rtl/tst_queue.sv
rtl/tst_back.sv
rtl/triangle_strip_tessellator.sv
tb/sv/tessellation_checker.sv
tb/sv/tb_top.sv
